// ===== hw/rtl/sfna_pkg.sv =====
// Package for the smallest free number allocator.
// Holds sizes, types, action codes and the bit search helpers.
// No dependencies; every other file uses it by scoped names.
package sfna_pkg;

    // Size of the number space and the word organization of the bitmap.
    localparam int SET_SIZE = 1024;
    localparam int NUM_W    = 10;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int ROWS     = SET_SIZE / WORD_W;
    localparam int ROW_W    = $clog2(ROWS);

    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BIT_W-1:0]  bitidx_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [ROWS-1:0]   rowmap_t;

    // Action codes of an input item.
    localparam logic ACT_POP = 1'b0;
    localparam logic ACT_ADD = 1'b1;

    // Access to the bitmap memory: one read and one write command.
    typedef struct packed {
        logic  rd_en;
        row_t  rd_row;
        logic  wr_en;
        row_t  wr_row;
        word_t wr_word;
    } map_cmd_t;

    // Contents of a row after reset: all present, except number zero.
    function automatic word_t init_word(input row_t row);
        word_t w;
        w = '1;
        if (row == '0)
        begin
            w[0] = 1'b0;
        end
        return w;
    endfunction

    // Bits strictly above the given bit position.
    function automatic word_t bits_above(input bitidx_t b);
        word_t m;
        for (int i = 0; i < WORD_W; i++)
        begin
            m[i] = (BIT_W'(i) > b);
        end
        return m;
    endfunction

    // Rows strictly above the given row.
    function automatic rowmap_t rows_above(input row_t r);
        rowmap_t m;
        for (int i = 0; i < ROWS; i++)
        begin
            m[i] = (ROW_W'(i) > r);
        end
        return m;
    endfunction

    // Position of the lowest set bit of a word.
    function automatic bitidx_t lowest_bit(input word_t w);
        bitidx_t idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit of a row map.
    function automatic row_t lowest_row(input rowmap_t m);
        row_t idx;
        idx = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = ROW_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/sfna_if.sv =====
// Handshake channels of the smallest free number allocator.
// Request channel carries the action and number; result channel the popped value and empty flag.
// Depends on sfna_pkg for the field types.
interface sfna_req_if;
    logic          valid;
    logic          ready;
    logic          action;
    sfna_pkg::num_t number;

    modport source (output valid, output action, output number, input ready);
    modport sink   (input valid, input action, input number, output ready);
endinterface

interface sfna_rsp_if;
    logic          valid;
    logic          ready;
    sfna_pkg::num_t value;
    logic          empty_res;

    modport source (output valid, output value, output empty_res, input ready);
    modport sink   (input valid, input value, input empty_res, output ready);
endinterface

// ===== hw/rtl/smallest_free_number_allocator.sv =====
// Smallest free number allocator: hands out the lowest free number of 1..1023.
// req carries an action (pop or add back) and a number; rsp returns one item per pop.
// A pop result holds the popped number, or zero with empty_res set when nothing is
// free. An add-back item marks its number free again and gives no result; zero is
// ignored. The free set is a 32 x 32 bit word memory with a 32-bit row summary.
// Timing: a pop result is in the rsp register in the cycle after the item is taken,
// since the smallest free number is kept in a register. The block then updates
// the bitmap: an add-back reads its word and writes it back in ST_MOD (an add of
// zero or an empty pop makes no update), a pop finding the next free number in the
// same word does the same, and a pop that must go to a later word then reads that
// word in ST_FIND for its lowest set bit. req.ready is low while an update runs
// and while a finished result waits in rsp with rsp.ready low, so new items wait.
// After reset all numbers from 1 up are free, the pointer is 1, and no clearing
// pass is needed: rows never written read as their reset contents.
// Depends on sfna_pkg, sfna_if and sfna_map.
module smallest_free_number_allocator
(
    input  logic             clk,
    input  logic             rst_n,
    sfna_req_if.sink         req,
    sfna_rsp_if.source       rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_FIND = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    sfna_pkg::num_t     ptr_reg, ptr_next;
    logic               act_reg, act_next;
    sfna_pkg::num_t     num_reg, num_next;
    sfna_pkg::row_t     row2_reg, row2_next;
    logic               out_valid_reg, out_valid_next;
    sfna_pkg::num_t     out_value_reg, out_value_next;
    logic               out_empty_reg, out_empty_next;

    sfna_pkg::map_cmd_t cmd;
    sfna_pkg::word_t    rd_word;
    sfna_pkg::rowmap_t  summary;

    logic               accept;
    sfna_pkg::row_t     cur_row;
    sfna_pkg::bitidx_t  cur_bit;
    sfna_pkg::word_t    cur_mask;
    sfna_pkg::word_t    new_word;
    sfna_pkg::word_t    rest;
    sfna_pkg::rowmap_t  later_rows;

    sfna_map u_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_word (rd_word),
        .summary (summary)
    );

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.value     = out_value_reg;
    assign rsp.empty_res = out_empty_reg;

    // Word being modified and what is left above the removed bit.
    assign cur_row    = num_reg[sfna_pkg::NUM_W-1:sfna_pkg::BIT_W];
    assign cur_bit    = num_reg[sfna_pkg::BIT_W-1:0];
    assign cur_mask   = sfna_pkg::word_t'(1) << cur_bit;
    assign new_word   = (act_reg == sfna_pkg::ACT_POP) ? (rd_word & ~cur_mask)
                                                       : (rd_word | cur_mask);
    assign rest       = new_word & sfna_pkg::bits_above(cur_bit);
    assign later_rows = summary & sfna_pkg::rows_above(cur_row);

    // Sequencer: accept, read-modify-write, and the search for the next free number.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        act_next       = act_reg;
        num_next       = num_reg;
        row2_next      = row2_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_empty_next = out_empty_reg;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next = req.action;
                    if (req.action == sfna_pkg::ACT_POP)
                    begin
                        // The result is known at once from the pointer.
                        out_valid_next = 1'b1;
                        out_value_next = ptr_reg;
                        out_empty_next = (ptr_reg == '0);
                        num_next       = ptr_reg;
                        if (ptr_reg != '0)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_row = ptr_reg[sfna_pkg::NUM_W-1:sfna_pkg::BIT_W];
                            state_next = ST_MOD;
                        end
                    end
                    else if (req.number != '0)
                    begin
                        num_next   = req.number;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_row = req.number[sfna_pkg::NUM_W-1:sfna_pkg::BIT_W];
                        if (ptr_reg == '0 || req.number < ptr_reg)
                        begin
                            ptr_next = req.number;
                        end
                        state_next = ST_MOD;
                    end
                end
            end

            ST_MOD:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_row  = cur_row;
                cmd.wr_word = new_word;
                state_next  = ST_IDLE;
                if (act_reg == sfna_pkg::ACT_POP)
                begin
                    if (rest != '0)
                    begin
                        ptr_next = {cur_row, sfna_pkg::lowest_bit(rest)};
                    end
                    else if (later_rows != '0)
                    begin
                        // Next free number lies in a later word: fetch it.
                        row2_next  = sfna_pkg::lowest_row(later_rows);
                        cmd.rd_en  = 1'b1;
                        cmd.rd_row = sfna_pkg::lowest_row(later_rows);
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        ptr_next = '0;
                    end
                end
            end

            ST_FIND:
            begin
                ptr_next   = {row2_reg, sfna_pkg::lowest_bit(rd_word)};
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= sfna_pkg::num_t'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        num_reg       <= num_next;
        row2_reg      <= row2_next;
        out_value_reg <= out_value_next;
        out_empty_reg <= out_empty_next;
    end

endmodule

// ===== hw/rtl/sfna_map.sv =====
// Presence bitmap of the allocator: a word memory with one read and one write port,
// row valid bits standing in for the reset contents, and a per-row summary vector.
// Depends on sfna_pkg.
module sfna_map
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfna_pkg::map_cmd_t  cmd,
    output sfna_pkg::word_t     rd_word,
    output sfna_pkg::rowmap_t   summary
);

    sfna_pkg::word_t   word_mem [sfna_pkg::ROWS];
    sfna_pkg::word_t   rd_data_reg;
    sfna_pkg::row_t    rd_row_reg;
    logic              rd_valid_reg;
    sfna_pkg::rowmap_t row_valid_reg;
    sfna_pkg::rowmap_t summary_reg;

    // Memory array with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            word_mem[cmd.wr_row] <= cmd.wr_word;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= word_mem[cmd.rd_row];
            rd_row_reg  <= cmd.rd_row;
        end
    end

    // Row valid bits and the summary of nonempty rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            summary_reg   <= '1;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[cmd.rd_row];
            end
            if (cmd.wr_en)
            begin
                row_valid_reg[cmd.wr_row] <= 1'b1;
                summary_reg[cmd.wr_row]   <= |cmd.wr_word;
            end
        end
    end

    // A row never written reads as its reset contents.
    assign rd_word = rd_valid_reg ? rd_data_reg : sfna_pkg::init_word(rd_row_reg);
    assign summary = summary_reg;

endmodule
